@@ src/pmhg_pkg.sv @@
// shared types, constants and helpers for the minimum-height gridder
package pmhg_pkg;

  localparam int MAX_DIM   = 256;
  localparam int DIM_W     = 9;
  localparam int CELL_W    = 16;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int OCC_BW    = 5;
  localparam int OCC_WORDS = CELLS / (1 << OCC_BW);
  localparam int OCC_AW    = CELL_W - OCC_BW;
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int DIV_CNT_W = $clog2(COORD_W);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] CFG_X_BASE = 3'd0;
  localparam logic [2:0] CFG_Y_BASE = 3'd1;
  localparam logic [2:0] CFG_PITCH  = 3'd2;
  localparam logic [2:0] CFG_ROWS   = 3'd3;
  localparam logic [2:0] CFG_COLS   = 3'd4;
  localparam logic [2:0] CFG_NODATA = 3'd5;

  typedef enum logic [2:0] {
    K_NOP,
    K_CLEAR,
    K_ADD,
    K_REJECT,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [COORD_W-1:0]   dx;
    logic [COORD_W-1:0]   dy;
    logic [COORD_W-1:0]   z;
    logic [CELL_W-1:0]    read_index;
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_base;
    logic [COORD_W-1:0] y_base;
    logic [SIZE_W-1:0]  bin_pitch;
    logic [DIM_W-1:0]   grid_rows;
    logic [DIM_W-1:0]   grid_cols;
    logic [COORD_W-1:0] nodata_value;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_DIV,
    BK_BIN,
    BK_RCHK,
    BK_LOOK,
    BK_CHECK
  } bk_state_t;

  function automatic logic [DIM_W-1:0] dim_used(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (d > lim) ? lim : d;
  endfunction

endpackage

@@ src/pmhg_front.sv @@
// request classification: op decode, offsets from the grid origin, reject check
module pmhg_front (
  input  logic [1:0]                   in_op,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_x,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_y,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_z,
  input  logic [pmhg_pkg::CELL_W-1:0]  in_read_index,
  input  pmhg_pkg::cfg_t               cfg,
  output pmhg_pkg::job_t               job
);
  import pmhg_pkg::*;

  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic             reject;

  assign dx = {in_point_x[COORD_W-1], in_point_x} - {cfg.x_base[COORD_W-1], cfg.x_base};
  assign dy = {cfg.y_base[COORD_W-1], cfg.y_base} - {in_point_y[COORD_W-1], in_point_y};
  assign reject = (cfg.bin_pitch == '0) || dx[COORD_W] || dy[COORD_W];

  always_comb begin
    job.dx         = dx[COORD_W-1:0];
    job.dy         = dy[COORD_W-1:0];
    job.z          = in_point_z;
    job.read_index = in_read_index;
    case (in_op)
      OP_CLEAR: job.kind = K_CLEAR;
      OP_ADD:   job.kind = reject ? K_REJECT : K_ADD;
      OP_READ:  job.kind = K_READ;
      default:  job.kind = K_NOP;
    endcase
  end

endmodule

@@ src/pmhg_fifo.sv @@
// two-entry request queue between front and back
module pmhg_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pmhg_pkg::job_t       din,
  input  logic                 pop,
  output pmhg_pkg::job_t       dout,
  output pmhg_pkg::fifo_stat_t stat
);
  import pmhg_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/pmhg_div.sv @@
// two-lane restoring divider, one quotient bit per lane per cycle, shared divisor
module pmhg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pmhg_pkg::COORD_W-1:0] dividend_a,
  input  logic [pmhg_pkg::COORD_W-1:0] dividend_b,
  input  logic [pmhg_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [pmhg_pkg::COORD_W-1:0] quo_a,
  output logic [pmhg_pkg::COORD_W-1:0] quo_b
);
  import pmhg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    div_r, div_nxt;
  logic [SIZE_W-1:0]    rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic [COORD_W-1:0]   quo_a_r, quo_a_nxt, quo_b_r, quo_b_nxt;
  logic [COORD_W-1:0]   sh_a, sh_b, dv;
  logic [COORD_W-1:0]   df_a, df_b;
  logic                 ge_a, ge_b;

  assign done  = done_r;
  assign quo_a = quo_a_r;
  assign quo_b = quo_b_r;

  always_comb begin
    sh_a = {rem_a_r, quo_a_r[COORD_W-1]};
    sh_b = {rem_b_r, quo_b_r[COORD_W-1]};
    dv   = {1'b0, div_r};
    ge_a = sh_a >= dv;
    ge_b = sh_b >= dv;
    df_a = sh_a - dv;
    df_b = sh_b - dv;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_a_nxt = rem_a_r;
    rem_b_nxt = rem_b_r;
    quo_a_nxt = quo_a_r;
    quo_b_nxt = quo_b_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      div_nxt   = divisor;
      rem_a_nxt = '0;
      rem_b_nxt = '0;
      quo_a_nxt = dividend_a;
      quo_b_nxt = dividend_b;
    end else if (busy_r) begin
      rem_a_nxt = ge_a ? df_a[SIZE_W-1:0] : sh_a[SIZE_W-1:0];
      rem_b_nxt = ge_b ? df_b[SIZE_W-1:0] : sh_b[SIZE_W-1:0];
      quo_a_nxt = {quo_a_r[COORD_W-2:0], ge_a};
      quo_b_nxt = {quo_b_r[COORD_W-2:0], ge_b};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(COORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    quo_a_r <= quo_a_nxt;
    quo_b_r <= quo_b_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

@@ src/pmhg_back.sv @@
// back end: binning, height and occupancy memories, clear sweep, result register
module pmhg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmhg_pkg::cfg_t               cfg,
  input  pmhg_pkg::fifo_stat_t         fstat,
  input  pmhg_pkg::job_t               head,
  output logic                         pop,
  output logic                         init_busy,
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic                         out_updated,
  output logic [pmhg_pkg::CELL_W-1:0]  out_cell_index,
  output logic                         out_cell_valid,
  output logic [pmhg_pkg::COORD_W-1:0] out_cell_height
);
  import pmhg_pkg::*;

  bk_state_t state_r, state_nxt;
  job_t      job_r, job_nxt;
  logic [OCC_AW-1:0] sweep_r, sweep_nxt;
  logic [CELL_W-1:0] addr_r, addr_nxt;

  logic                div_start, div_done;
  logic [COORD_W-1:0]  quo_a, quo_b;

  logic [DIM_W-1:0]    rows_u, cols_u;
  logic                bin_in;
  logic [CELL_W:0]     bin_cell;
  logic [CELL_W:0]     area;
  logic                rd_in;
  logic                sweep_last;

  logic [COORD_W-1:0]  hmem [CELLS];
  logic [COORD_W-1:0]  h_q;
  logic                h_we;
  logic [(1<<OCC_BW)-1:0] omem [OCC_WORDS];
  logic [(1<<OCC_BW)-1:0] o_q, o_wd;
  logic                o_we;
  logic [OCC_AW-1:0]   o_wa;
  logic                occ, lower;

  logic                res_fire;
  logic                res_acc, res_upd, res_cv;
  logic [CELL_W-1:0]   res_idx;
  logic [COORD_W-1:0]  res_h;

  logic                ov_r;
  logic                oacc_r, oupd_r, ocv_r;
  logic [CELL_W-1:0]   oidx_r;
  logic [COORD_W-1:0]  oh_r;

  pmhg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_a (head.dx),
    .dividend_b (head.dy),
    .divisor    (cfg.bin_pitch),
    .done       (div_done),
    .quo_a      (quo_a),
    .quo_b      (quo_b)
  );

  assign rows_u     = dim_used(cfg.grid_rows);
  assign cols_u     = dim_used(cfg.grid_cols);
  assign bin_in     = (quo_b < COORD_W'(rows_u)) && (quo_a < COORD_W'(cols_u));
  assign bin_cell   = (CELL_W+1)'(quo_b[7:0]) * (CELL_W+1)'(cols_u) + (CELL_W+1)'(quo_a[7:0]);
  assign area       = (CELL_W+1)'(rows_u) * (CELL_W+1)'(cols_u);
  assign rd_in      = {1'b0, job_r.read_index} < area;
  assign sweep_last = sweep_r == OCC_AW'(OCC_WORDS - 1);
  assign occ        = o_q[addr_r[OCC_BW-1:0]];
  assign lower      = !occ || ($signed(job_r.z) < $signed(h_q));
  assign init_busy  = state_r == BK_INIT;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_INIT:  if (sweep_last) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!fstat.empty) begin
          case (head.kind)
            K_CLEAR: state_nxt = BK_CLEAR;
            K_ADD:   state_nxt = BK_DIV;
            K_READ:  state_nxt = BK_RCHK;
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CLEAR: if (sweep_last) state_nxt = BK_IDLE;
      BK_DIV:   if (div_done) state_nxt = BK_BIN;
      BK_BIN:   state_nxt = bin_in ? BK_LOOK : BK_IDLE;
      BK_RCHK:  state_nxt = rd_in ? BK_LOOK : BK_IDLE;
      BK_LOOK:  state_nxt = BK_CHECK;
      BK_CHECK: state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    job_nxt   = job_r;
    sweep_nxt = sweep_r;
    addr_nxt  = addr_r;
    h_we      = 1'b0;
    o_we      = 1'b0;
    o_wa      = addr_r[CELL_W-1:OCC_BW];
    o_wd      = o_q | ((1 << OCC_BW)'(1) << addr_r[OCC_BW-1:0]);
    res_fire  = 1'b0;
    res_acc   = 1'b0;
    res_upd   = 1'b0;
    res_cv    = 1'b0;
    res_idx   = '0;
    res_h     = '0;
    case (state_r)
      BK_INIT, BK_CLEAR: begin
        o_we      = 1'b1;
        o_wa      = sweep_r;
        o_wd      = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_last && state_r == BK_CLEAR) res_fire = 1'b1;
      end
      BK_IDLE: begin
        if (!fstat.empty) begin
          pop       = 1'b1;
          job_nxt   = head;
          sweep_nxt = '0;
          div_start = head.kind == K_ADD;
          res_fire  = (head.kind == K_NOP) || (head.kind == K_REJECT);
        end
      end
      BK_BIN: begin
        addr_nxt = bin_cell[CELL_W-1:0];
        res_fire = !bin_in;
      end
      BK_RCHK: begin
        addr_nxt = job_r.read_index;
        if (!rd_in) begin
          res_fire = 1'b1;
          res_idx  = job_r.read_index;
          res_h    = cfg.nodata_value;
        end
      end
      BK_CHECK: begin
        res_fire = 1'b1;
        res_idx  = addr_r;
        if (job_r.kind == K_ADD) begin
          h_we    = lower;
          o_we    = 1'b1;
          res_acc = 1'b1;
          res_upd = lower;
          res_cv  = 1'b1;
          res_h   = lower ? job_r.z : h_q;
        end else begin
          res_cv = occ;
          res_h  = occ ? h_q : cfg.nodata_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[addr_r] <= job_r.z;
    h_q <= hmem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_wa] <= o_wd;
    o_q <= omem[addr_r[CELL_W-1:OCC_BW]];
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    addr_r  <= addr_nxt;
    oacc_r  <= res_acc;
    oupd_r  <= res_upd;
    ocv_r   <= res_cv;
    oidx_r  <= res_idx;
    oh_r    <= res_h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_INIT;
      sweep_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      ov_r    <= res_fire;
    end
  end

  assign out_valid       = ov_r;
  assign out_accepted    = oacc_r;
  assign out_updated     = oupd_r;
  assign out_cell_index  = oidx_r;
  assign out_cell_valid  = ocv_r;
  assign out_cell_height = oh_r;

  a_upd_implies_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oupd_r) |-> (oacc_r && ocv_r))
    else $error("update reported on a point that was not binned");

  a_bin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_BIN) |-> ($past(state_r) == BK_DIV && $past(div_done)))
    else $error("binning entered without a finished division");

  a_check_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHECK) |-> ($past(state_r) == BK_LOOK))
    else $error("memory data used without a lookup cycle");

endmodule

@@ src/point_min_height_gridder.sv @@
// top level of the minimum-height point gridder
//
//  channel  ports                                     handshake
//  in       in_op, in_point_x/y/z, in_read_index      start & !busy
//  out      out_accepted .. out_cell_height           out_valid, one cycle
//  cfg      cfg_index, cfg_data                       cfg_valid & cfg_ready
//
//  add: the back end runs the bit-serial divider (32 steps + done), then bin, lookup and check
//  read: range check, lookup and check; clear and reset: sweep of all 2048 occupancy memory words
//  busy is high during the reset sweep and while the 2-entry queue is full
//  results cannot be stalled; cfg_ready is always high
module point_min_height_gridder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_x,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_y,
  input  logic [pmhg_pkg::COORD_W-1:0] in_point_z,
  input  logic [pmhg_pkg::CELL_W-1:0]  in_read_index,
  output logic                         out_valid,
  output logic                         out_accepted,
  output logic                         out_updated,
  output logic [pmhg_pkg::CELL_W-1:0]  out_cell_index,
  output logic                         out_cell_valid,
  output logic [pmhg_pkg::COORD_W-1:0] out_cell_height,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [pmhg_pkg::COORD_W-1:0] cfg_data
);
  import pmhg_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  job_t       front_job, head;
  fifo_stat_t fstat;
  logic       push, pop, init_busy;

  assign cfg_ready = 1'b1;
  assign busy      = fstat.full || init_busy;
  assign push      = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_X_BASE: cfg_nxt.x_base       = cfg_data;
        CFG_Y_BASE: cfg_nxt.y_base       = cfg_data;
        CFG_PITCH:  cfg_nxt.bin_pitch    = cfg_data[SIZE_W-1:0];
        CFG_ROWS:   cfg_nxt.grid_rows    = cfg_data[DIM_W-1:0];
        CFG_COLS:   cfg_nxt.grid_cols    = cfg_data[DIM_W-1:0];
        CFG_NODATA: cfg_nxt.nodata_value = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_base       <= '0;
      cfg_r.y_base       <= '0;
      cfg_r.bin_pitch    <= SIZE_W'(256);
      cfg_r.grid_rows    <= DIM_W'(MAX_DIM);
      cfg_r.grid_cols    <= DIM_W'(MAX_DIM);
      cfg_r.nodata_value <= {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pmhg_front u_front (
    .in_op         (in_op),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_read_index (in_read_index),
    .cfg           (cfg_r),
    .job           (front_job)
  );

  pmhg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_job),
    .pop   (pop),
    .dout  (head),
    .stat  (fstat)
  );

  pmhg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .fstat           (fstat),
    .head            (head),
    .pop             (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_updated     (out_updated),
    .out_cell_index  (out_cell_index),
    .out_cell_valid  (out_cell_valid),
    .out_cell_height (out_cell_height)
  );

endmodule
